>>> hw/rtl/multibyte_character_splitter_assert.svh
// Assertion macros for the splitter RTL.
`ifndef MULTIBYTE_CHARACTER_SPLITTER_ASSERT_SVH
`define MULTIBYTE_CHARACTER_SPLITTER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define MBCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbcs: same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define MBCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbcs: next-cycle check failed");

`endif

>>> hw/rtl/mbcs_pkg.sv
package mbcs_pkg;

  // Code page register values
  typedef enum logic [2:0] {
    CP_SINGLE       = 3'd0,
    CP_JAPANESE     = 3'd1,
    CP_SIMP_CHINESE = 3'd2,
    CP_TRAD_CHINESE = 3'd3,
    CP_WANSUNG      = 3'd4,
    CP_JOHAB        = 3'd5
  } code_page_t;

  localparam logic [7:0]  ESCAPE_LEAD = 8'h7C;   // '|'
  localparam logic [14:0] OFFSET_MAX  = 15'h7FFF;

  // Result queue: holds up to two results of each accepted byte
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [15:0] char_code;
    logic        is_double;
    logic [14:0] start_offset;
    logic        is_last;
  } result_t;

  // Letters that follow '|' to form an escape pair
  function automatic logic is_escape_letter(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c) inside
      "i", "b", "u", "k", "p", "r", "l", "c", "t", "n": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Add to the offset and clamp at the top of the 15-bit range
  function automatic logic [14:0] offset_add(input logic [14:0] base,
                                             input logic [1:0]  inc);
    logic [15:0] sum;
    sum = {1'b0, base} + {14'd0, inc};
    return sum[15] ? OFFSET_MAX : sum[14:0];
  endfunction

endpackage

>>> hw/rtl/mbcs_pair_detect.sv
module mbcs_pair_detect (
  input  logic [2:0] code_page,
  input  logic [7:0] lead,
  input  logic [7:0] trail,
  output logic       pair
);
  import mbcs_pkg::*;

  logic lead_ok;
  logic trail_ok;
  logic escape;

  // Escape pairs apply on every code page
  assign escape = (lead == ESCAPE_LEAD) && is_escape_letter(trail);

  // Lead and trail ranges of the selected code page
  always_comb begin
    lead_ok  = 1'b0;
    trail_ok = 1'b0;
    case (code_page)
      CP_JAPANESE: begin
        lead_ok  = (lead inside {[8'h81:8'h9F], [8'hE0:8'hFD], 8'hFF});
        trail_ok = (trail inside {[8'h40:8'h7E], [8'h80:8'hFC]});
      end
      CP_SIMP_CHINESE: begin
        lead_ok  = (lead inside {[8'hA1:8'hFD], 8'hFF});
        trail_ok = (trail inside {[8'hA1:8'hFD], 8'hFF});
      end
      CP_TRAD_CHINESE: begin
        lead_ok  = (lead inside {[8'h81:8'hFD], 8'hFF});
        trail_ok = (trail inside {[8'h40:8'h7E], [8'hA1:8'hFD], 8'hFF});
      end
      CP_WANSUNG: begin
        lead_ok  = (lead inside {[8'h81:8'hFD], 8'hFF});
        trail_ok = (trail inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h81:8'hFD], 8'hFF});
      end
      CP_JOHAB: begin
        lead_ok  = (lead inside {[8'h84:8'hD3], [8'hD8:8'hDE], [8'hE0:8'hF9]});
        trail_ok = (trail inside {[8'h41:8'h7E], [8'h81:8'hFD], 8'hFF});
      end
      default: begin
        lead_ok  = 1'b0;
        trail_ok = 1'b0;
      end
    endcase
  end

  assign pair = (lead != 8'd0) && (trail != 8'd0) && (escape || (lead_ok && trail_ok));

endmodule

>>> hw/rtl/multibyte_character_splitter.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_byte
// out     | output    | out_valid / out_ready| char_code, is_double, start_offset, is_last
// cfg     | input     | cfg_valid / cfg_ready| code_page
//
// One byte is taken per cycle while in_ready is high; it yields zero, one or two results.
// Results go through a four-entry queue; in_ready is high while two entries are free,
// so a stream of single results runs at one per cycle with out_ready held high.
// A zero byte after a held byte gives two results, each in its own output transfer.
// Synchronous active-high reset empties the queue, drops the held byte, zeroes the offset.
// cfg_ready is always high; code_page is registered whenever cfg_valid is high.
module multibyte_character_splitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] char_code,
  output logic        is_double,
  output logic [14:0] start_offset,
  output logic        is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  code_page
);
  import mbcs_pkg::*;

  logic [2:0]       code_page_reg;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic [14:0]      byte_count, byte_count_next;
  result_t          queue [QUEUE_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count, count_next;
  logic             in_xfer, out_xfer, pair;
  logic [1:0]       push_n;
  result_t          res0, res1;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_xfer  = out_valid && out_ready;

  mbcs_pair_detect u_pair (
    .code_page (code_page_reg),
    .lead      (held_byte),
    .trail     (in_byte),
    .pair      (pair)
  );

  // Decode one byte against the held byte
  always_comb begin
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    byte_count_next = byte_count;
    push_n          = 2'd0;
    res0            = '{char_code: {8'd0, held_byte}, is_double: 1'b0,
                        start_offset: byte_count, is_last: 1'b0};
    res1            = '{char_code: 16'd0, is_double: 1'b0,
                        start_offset: offset_add(byte_count, 2'd1), is_last: 1'b1};
    if (in_byte == 8'd0) begin
      // flush held byte, then terminator
      if (held_valid) begin
        push_n = 2'd2;
      end else begin
        push_n = 2'd1;
        res0   = '{char_code: 16'd0, is_double: 1'b0,
                   start_offset: byte_count, is_last: 1'b1};
      end
      held_valid_next = 1'b0;
      held_byte_next  = 8'd0;
      byte_count_next = '0;
    end else if (!held_valid) begin
      held_byte_next  = in_byte;
      held_valid_next = 1'b1;
    end else if (pair) begin
      push_n          = 2'd1;
      res0.char_code  = {held_byte, in_byte};
      res0.is_double  = 1'b1;
      held_valid_next = 1'b0;
      held_byte_next  = 8'd0;
      byte_count_next = offset_add(byte_count, 2'd2);
    end else begin
      push_n          = 2'd1;
      held_byte_next  = in_byte;
      byte_count_next = offset_add(byte_count, 2'd1);
    end
  end

  // Advance decode state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_page_reg <= CP_SINGLE;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      byte_count    <= '0;
      head          <= '0;
      tail          <= '0;
      count         <= '0;
    end else begin
      if (cfg_valid) begin
        code_page_reg <= code_page;
      end
      if (in_xfer) begin
        held_byte  <= held_byte_next;
        held_valid <= held_valid_next;
        byte_count <= byte_count_next;
        tail       <= tail + PTR_W'(push_n);
      end
      if (out_xfer) begin
        head <= head + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_comb begin
    count_next = count;
    if (in_xfer) begin
      count_next = count_next + CNT_W'(push_n);
    end
    if (out_xfer) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) begin
      queue[tail] <= res0;
    end
    if (in_xfer && push_n == 2'd2) begin
      queue[tail + PTR_W'(1)] <= res1;
    end
  end

  // Drive the head entry
  assign char_code    = queue[head].char_code;
  assign is_double    = queue[head].is_double;
  assign start_offset = queue[head].start_offset;
  assign is_last      = queue[head].is_last;

`include "multibyte_character_splitter_assert.svh"

  `MBCS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(QUEUE_DEPTH))
  `MBCS_ASSERT_NEXT(a_zero_clears, clk, rst, in_xfer && in_byte == 8'd0, !held_valid && byte_count == '0)
  `MBCS_ASSERT_NEXT(a_zero_emits, clk, rst, in_xfer && in_byte == 8'd0, out_valid)
  `MBCS_ASSERT_NEXT(a_first_held, clk, rst, in_xfer && in_byte != 8'd0 && !held_valid, held_valid && held_byte == $past(in_byte))

endmodule

>>> tb/sv/tb_multibyte_character_splitter.sv
module tb_multibyte_character_splitter;
  import mbcs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int REPORT_CAP = 100;
  localparam logic [2:0] CP_SPARE_HI = 3'd7;
  localparam logic [7:0] TERMINATOR = 8'h00;

  // Letters that pair with a leading '|'
  localparam logic [7:0] ESC_LETTERS [10] = '{
    8'h69, 8'h62, 8'h75, 8'h6B, 8'h70, 8'h72, 8'h6C, 8'h63, 8'h74, 8'h6E
  };

  // Bytes at and around every lead and trail range boundary
  localparam logic [7:0] EDGE_BYTES [30] = '{
    8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B, 8'h7E, 8'h7F,
    8'h80, 8'h81, 8'h83, 8'h84, 8'h9F, 8'hA0, 8'hA1, 8'hD3, 8'hD4, 8'hD7,
    8'hD8, 8'hDE, 8'hDF, 8'hE0, 8'hF9, 8'hFA, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] char_code;
  logic        is_double;
  logic [14:0] start_offset;
  logic        is_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  code_page;

  // Stimulus knobs
  int          gap_pct;
  int          stall_pct;
  logic        rx_hold;
  logic [2:0]  page_sel;

  // Predictor state
  logic [2:0]  page_q;
  logic [7:0]  held_b;
  logic        held_v;
  logic [14:0] char_offset;
  result_t     chars_due [$];

  int          mismatch_count;
  int          cycle_count;

  multibyte_character_splitter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .char_code    (char_code),
    .is_double    (is_double),
    .start_offset (start_offset),
    .is_last      (is_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .code_page    (code_page)
  );

  always #2 clk = ~clk;

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the output side at random, or hold it off completely
  always @(posedge clk) begin
    if (rx_hold)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit in_span(input logic [7:0] v, input logic [7:0] lo,
                                 input logic [7:0] hi);
    return v >= lo && v <= hi;
  endfunction

  function automatic bit escape_letter(input logic [7:0] c);
    for (int k = 0; k < 10; k++)
      if (c == ESC_LETTERS[k]) return 1'b1;
    return 1'b0;
  endfunction

  // Decide whether a held byte and a new byte make one character
  function automatic bit pair_ok(input logic [2:0] cp, input logic [7:0] ld,
                                 input logic [7:0] tr);
    if (ld == 8'h00 || tr == 8'h00) return 1'b0;
    if (ld == ESCAPE_LEAD && escape_letter(tr)) return 1'b1;
    case (cp)
      CP_JAPANESE:
        return (in_span(ld, 8'h81, 8'h9F) || (ld >= 8'hE0 && ld != 8'hFE)) &&
               in_span(tr, 8'h40, 8'hFC) && tr != 8'h7F;
      CP_SIMP_CHINESE:
        return ld >= 8'hA1 && ld != 8'hFE && tr >= 8'hA1 && tr != 8'hFE;
      CP_TRAD_CHINESE:
        return ld >= 8'h81 && ld != 8'hFE &&
               (in_span(tr, 8'h40, 8'h7E) || (tr >= 8'hA1 && tr != 8'hFE));
      CP_WANSUNG:
        return ld >= 8'h81 && ld != 8'hFE &&
               (in_span(tr, 8'h41, 8'h5A) || in_span(tr, 8'h61, 8'h7A) ||
                (tr >= 8'h81 && tr != 8'hFE));
      CP_JOHAB:
        return (in_span(ld, 8'h84, 8'hD3) || in_span(ld, 8'hD8, 8'hDE) ||
                in_span(ld, 8'hE0, 8'hF9)) &&
               (in_span(tr, 8'h41, 8'h7E) || (tr >= 8'h81 && tr != 8'hFE));
      default:
        return 1'b0;
    endcase
  endfunction

  function automatic logic [14:0] bump_offset(input logic [14:0] base, input int n);
    int sum;
    sum = int'(base) + n;
    return (sum > 32767) ? 15'h7FFF : 15'(sum);
  endfunction

  task automatic queue_char(input logic [15:0] code, input logic dbl, input logic last);
    result_t r;
    r.char_code = code;
    r.is_double = dbl;
    r.start_offset = char_offset;
    r.is_last = last;
    chars_due.push_back(r);
  endtask

  // Work out the characters that one accepted byte releases
  task automatic split_byte(input logic [7:0] b);
    if (b == TERMINATOR) begin
      if (held_v) begin
        queue_char({8'h00, held_b}, 1'b0, 1'b0);
        char_offset = bump_offset(char_offset, 1);
        held_v = 1'b0;
      end
      queue_char(16'h0000, 1'b0, 1'b1);
      char_offset = '0;
    end else if (!held_v) begin
      held_b = b;
      held_v = 1'b1;
    end else if (pair_ok(page_q, held_b, b)) begin
      queue_char({held_b, b}, 1'b1, 1'b0);
      char_offset = bump_offset(char_offset, 2);
      held_v = 1'b0;
    end else begin
      queue_char({8'h00, held_b}, 1'b0, 1'b0);
      char_offset = bump_offset(char_offset, 1);
      held_b = b;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("MISMATCH cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Compare one output transfer with the oldest character due
  task automatic check_char();
    result_t want;
    if (chars_due.size() == 0) begin
      report_mismatch("result with nothing due, char_code", char_code, 16'h0000);
      return;
    end
    want = chars_due.pop_front();
    if (char_code !== want.char_code)
      report_mismatch("char_code", char_code, want.char_code);
    if (is_double !== want.is_double)
      report_mismatch("is_double", 16'(is_double), 16'(want.is_double));
    if (start_offset !== want.start_offset)
      report_mismatch("start_offset", 16'(start_offset), 16'(want.start_offset));
    if (is_last !== want.is_last)
      report_mismatch("is_last", 16'(is_last), 16'(want.is_last));
  endtask

  // Track every transfer on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) page_q = code_page;
      if (in_valid && in_ready) split_byte(in_byte);
      if (out_valid && out_ready) check_char();
    end
  end

  // Offer one byte, with a random gap first, and hold it until transfer
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every character due, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_page(input logic [2:0] cp);
    wait_drained();
    cfg_valid <= 1'b1;
    code_page <= cp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    page_sel = cp;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(9))
      0: return TERMINATOR;
      1, 2, 3: return EDGE_BYTES[$urandom_range($size(EDGE_BYTES) - 1)];
      4: return ESCAPE_LEAD;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Draw a lead and trail that pair under the selected code page
  function automatic void pick_pair(output logic [7:0] ld, output logic [7:0] tr);
    for (int k = 0; k < 32; k++) begin
      ld = 8'($urandom_range(8'h81, 8'hFF));
      tr = 8'($urandom_range(8'h40, 8'hFF));
      if (pair_ok(page_sel, ld, tr)) return;
    end
    ld = ESCAPE_LEAD;
    tr = ESC_LETTERS[$urandom_range(9)];
  endfunction

  // Send mostly well-formed strings, with some noise and unterminated strings
  task automatic run_strings(input int n_items);
    int sent;
    int nchars;
    logic [7:0] ld;
    logic [7:0] tr;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        nchars = $urandom_range(1, 10);
        repeat (nchars) begin
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              send_byte(8'($urandom_range(1, 127)));
              sent++;
            end
            4: begin
              send_byte(ESCAPE_LEAD);
              send_byte(ESC_LETTERS[$urandom_range(9)]);
              sent += 2;
            end
            default: begin
              pick_pair(ld, tr);
              send_byte(ld);
              send_byte(tr);
              sent += 2;
            end
          endcase
        end
        if ($urandom_range(9) != 0) begin
          send_byte(TERMINATOR);
          sent++;
        end
      end else begin
        nchars = $urandom_range(1, 12);
        repeat (nchars) begin
          send_byte(noise_byte());
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    write_code_page(CP_SINGLE);
    // terminator alone, then single byte and terminator
    send_byte(TERMINATOR);
    send_byte(8'h41);
    send_byte(TERMINATOR);
    // escape pair, terminator offset after it
    send_byte(ESCAPE_LEAD);
    send_byte(8'h69);
    send_byte(TERMINATOR);
    // byte extremes as single characters
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(TERMINATOR);
    // spare code page: only escape pairs combine
    write_code_page(CP_SPARE_HI);
    send_byte(ESCAPE_LEAD);
    send_byte(8'h6E);
    send_byte(8'h81);
    send_byte(8'h40);
    send_byte(TERMINATOR);
    write_code_page(CP_JAPANESE);
    send_byte(8'h81);
    send_byte(8'h40);
    send_byte(8'hFC);
    send_byte(8'hFC);
    send_byte(TERMINATOR);
    write_code_page(CP_JOHAB);
    send_byte(8'hD8);
    send_byte(8'h41);
    send_byte(TERMINATOR);
  endtask

  // Hold off the output while bytes keep coming, so the input stalls
  task automatic test_backpressure();
    write_code_page(CP_TRAD_CHINESE);
    gap_pct = 0;
    stall_pct = 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (200) @(posedge clk);
        rx_hold <= 1'b0;
      end
      begin
        repeat (60) send_byte(noise_byte());
      end
    join
    wait_drained();
  endtask

  task automatic test_random_phase(input int gap, input int stall);
    gap_pct = gap;
    stall_pct = stall;
    for (int k = 0; k < 8; k++) begin
      write_code_page(3'(k));
      run_strings(41);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    code_page = CP_SINGLE;
    rx_hold = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    page_sel = CP_SINGLE;
    page_q = CP_SINGLE;
    held_b = 8'h00;
    held_v = 1'b0;
    char_offset = '0;
    mismatch_count = 0;
    cycle_count = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(79, 0);
    test_random_phase(0, 79);
    test_random_phase(26, 26);
    wait_drained();

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
